@@ rtl/hsvp_pkg.sv @@
// package: shared widths, constants and stage payload types for the hsv to rgb converter
`timescale 1ns / 1ps
`default_nettype none
package hsvp_pkg;

    // input and output field widths
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int CHAN_W  = 8;
    localparam int SECT_W  = 3;
    localparam int FRAC_W  = 6;
    localparam int PEAK_W  = 15;   // 255 * v, v <= 100
    localparam int COEF_W  = 13;   // level coefficient, <= 6000
    localparam int NUM_W   = 28;   // peak * coefficient, <= 153000000

    // arithmetic constants
    localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
    localparam int                HUE_SPAN    = 60;
    localparam int                SECT_COUNT  = 8;     // 511 / 60
    localparam logic [SECT_W-1:0] SECT_LAST   = 3'd5;
    localparam logic [COEF_W-1:0] COEF_PEAK   = 13'd6000;
    localparam logic [COEF_W-1:0] COEF_FLOOR  = 13'd60;

    // reciprocal of 600000 scaled by 2^48, rounded up; exact for numerators below 2^28
    localparam int                RECIP_W     = 29;
    localparam int                RECIP_SHIFT = 48;
    localparam logic [RECIP_W-1:0] RECIP      = 29'd469124962;
    localparam int                PROD_W      = NUM_W + RECIP_W;

    // hue sectors
    localparam logic [SECT_W-1:0] SECT_RED_UP   = 3'd0;
    localparam logic [SECT_W-1:0] SECT_GRN_PEAK = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_UP   = 3'd2;
    localparam logic [SECT_W-1:0] SECT_BLU_PEAK = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_UP   = 3'd4;

    // payload between the prep and scale sections
    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [PEAK_W-1:0] peak;
        logic [COEF_W-1:0] k_lo;
        logic [COEF_W-1:0] k_mid;
    } coef_t;

    // payload between the scale section and the output stage
    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] lo;
        logic [CHAN_W-1:0] mid;
    } level_t;

endpackage
`default_nettype wire

@@ rtl/hsvp_prep.sv @@
// prep section: clamp, hue sector split and level coefficients, two register stages
`timescale 1ns / 1ps
`default_nettype none
module hsvp_prep (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [hsvp_pkg::HUE_W-1:0]  hue,
    input  wire logic [hsvp_pkg::PCT_W-1:0]  saturation,
    input  wire logic [hsvp_pkg::PCT_W-1:0]  brightness,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output hsvp_pkg::coef_t                  out_coef
);
    import hsvp_pkg::*;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 en1;
    logic                 en2;
    logic [SECT_W-1:0]    sector_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic [PCT_W-1:0]     sat_reg;
    logic [PEAK_W-1:0]    peak_reg;
    coef_t                coef_reg;

    logic [3:0]           sect_full;
    logic [HUE_W-1:0]     frac_full;
    logic [PCT_W-1:0]     sat_c;
    logic [PCT_W-1:0]     bri_c;
    logic [SECT_W-1:0]    sector_next;
    logic [PEAK_W-1:0]    peak_next;
    logic [COEF_W-1:0]    k_lo;
    logic [COEF_W-1:0]    sf;
    coef_t                coef_next;

    // stage handshake
    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_coef  = coef_reg;

    // stage 1: clamp, sector and remainder within the sector
    always_comb begin
        sat_c = (saturation > PCT_MAX) ? PCT_MAX : saturation;
        bri_c = (brightness > PCT_MAX) ? PCT_MAX : brightness;
        sect_full = 4'd0;
        for (int i = 1; i <= SECT_COUNT; i++) begin
            if (hue >= HUE_W'(i * HUE_SPAN)) begin
                sect_full = 4'(i);
            end
        end
        frac_full   = hue - HUE_W'(sect_full) * HUE_W'(HUE_SPAN);
        sector_next = (sect_full > 4'(SECT_LAST)) ? SECT_LAST : sect_full[SECT_W-1:0];
        peak_next   = (PEAK_W'(bri_c) << 8) - PEAK_W'(bri_c);
    end

    // stage 2: floor and ramp coefficients over denominator 6000
    always_comb begin
        k_lo = COEF_W'(PCT_MAX - sat_reg) * COEF_FLOOR;
        sf   = COEF_W'(sat_reg) * COEF_W'(frac_reg);
        coef_next.sector = sector_reg;
        coef_next.peak   = peak_reg;
        coef_next.k_lo   = k_lo;
        // even sectors rise from the floor, odd ones fall from the peak
        coef_next.k_mid  = !sector_reg[0] ? (k_lo + sf) : (COEF_PEAK - sf);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en1) begin
            sector_reg <= sector_next;
            frac_reg   <= frac_full[FRAC_W-1:0];
            sat_reg    <= sat_c;
            peak_reg   <= peak_next;
        end
        if (en2) begin
            coef_reg <= coef_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/hsvp_scale.sv @@
// scale section: level numerators and reciprocal divide by 600000, two register stages
`timescale 1ns / 1ps
`default_nettype none
module hsvp_scale (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire hsvp_pkg::coef_t in_coef,
    output logic          out_valid,
    input  wire logic     out_ready,
    output hsvp_pkg::level_t out_level
);
    import hsvp_pkg::*;

    logic              v1_reg;
    logic              v2_reg;
    logic              en1;
    logic              en2;
    logic [SECT_W-1:0] sector_reg;
    logic [NUM_W-1:0]  n_hi_reg;
    logic [NUM_W-1:0]  n_lo_reg;
    logic [NUM_W-1:0]  n_mid_reg;
    level_t            level_reg;

    logic [PROD_W-1:0] p_hi;
    logic [PROD_W-1:0] p_lo;
    logic [PROD_W-1:0] p_mid;
    level_t            level_next;

    // stage handshake
    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_level = level_reg;

    // stage 2: quotient by reciprocal multiply, result fits the channel width
    always_comb begin
        p_hi  = PROD_W'(n_hi_reg)  * PROD_W'(RECIP);
        p_lo  = PROD_W'(n_lo_reg)  * PROD_W'(RECIP);
        p_mid = PROD_W'(n_mid_reg) * PROD_W'(RECIP);
        level_next.sector = sector_reg;
        level_next.hi     = p_hi[RECIP_SHIFT +: CHAN_W];
        level_next.lo     = p_lo[RECIP_SHIFT +: CHAN_W];
        level_next.mid    = p_mid[RECIP_SHIFT +: CHAN_W];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // stage 1: numerators over 600000
    always_ff @(posedge aclk) begin
        if (en1) begin
            sector_reg <= in_coef.sector;
            n_hi_reg   <= NUM_W'(in_coef.peak) * NUM_W'(COEF_PEAK);
            n_lo_reg   <= NUM_W'(in_coef.peak) * NUM_W'(in_coef.k_lo);
            n_mid_reg  <= NUM_W'(in_coef.peak) * NUM_W'(in_coef.k_mid);
        end
        if (en2) begin
            level_reg <= level_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/hsv_percent_to_rgb.sv @@
// top level: hsv (degrees, percent) to 8-bit rgb converter with output register
`timescale 1ns / 1ps
`default_nettype none
// Converts hue in degrees with saturation and value in percent to truncated 8-bit
// red, green and blue. Saturation and value above 100 are clamped to 100; hue of
// 360 and above uses the last sector while the ramp still takes hue mod 60. The
// block is a five-stage pipeline (clamp and sector split, coefficients, numerator
// multiply, reciprocal multiply for the divide by 600000, channel select into the
// output register): it takes one item per clock unless the output stalls. Each
// stage holds under backpressure on its own, so a stalled output fills empty stages
// before the input side stops.
module hsv_percent_to_rgb (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // hue[8:0], saturation[15:9], brightness[22:16], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsvp_pkg::*;

    logic   coef_valid;
    logic   coef_ready;
    coef_t  coef;
    logic   level_valid;
    logic   level_ready;
    level_t level;

    logic              out_valid_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;

    hsvp_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (s_tdata[8:0]),
        .saturation (s_tdata[15:9]),
        .brightness (s_tdata[22:16]),
        .out_valid  (coef_valid),
        .out_ready  (coef_ready),
        .out_coef   (coef)
    );

    hsvp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (coef_valid),
        .in_ready  (coef_ready),
        .in_coef   (coef),
        .out_valid (level_valid),
        .out_ready (level_ready),
        .out_level (level)
    );

    // output stage handshake
    assign level_ready = !out_valid_reg || m_tready;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {blue_reg, green_reg, red_reg};

    // sector picks which channel takes peak, floor or ramp level
    always_comb begin
        case (level.sector)
            SECT_RED_UP: begin
                red_next = level.hi;  green_next = level.mid; blue_next = level.lo;
            end
            SECT_GRN_PEAK: begin
                red_next = level.mid; green_next = level.hi;  blue_next = level.lo;
            end
            SECT_GRN_UP: begin
                red_next = level.lo;  green_next = level.hi;  blue_next = level.mid;
            end
            SECT_BLU_PEAK: begin
                red_next = level.lo;  green_next = level.mid; blue_next = level.hi;
            end
            SECT_BLU_UP: begin
                red_next = level.mid; green_next = level.lo;  blue_next = level.hi;
            end
            default: begin
                red_next = level.hi;  green_next = level.lo;  blue_next = level.mid;
            end
        endcase
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (level_ready) begin
            out_valid_reg <= level_valid;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (level_ready) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule
`default_nettype wire

@@ tb/hsv_percent_to_rgb_tb.sv @@
// testbench: hsv_percent_to_rgb checked against a predictor under random stream idling
`timescale 1ns / 1ps
module hsv_percent_to_rgb_tb;
    import hsvp_pkg::*;

    localparam int unsigned LEVEL_DEN  = 600000;
    localparam int RANDOM_ITEMS        = 1530;
    localparam int QUIET_TAIL          = 150;
    localparam int HOLD_AT             = 500;
    localparam int HOLD_CYCLES         = 80;
    localparam int DRAIN_CYCLES        = 12;
    localparam int STALL_LIMIT         = 2000;
    localparam int REPORT_MAX          = 10;
    localparam int DIRECTED_ROWS       = 24;

    // red in the lowest byte, as on m_tdata
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [PCT_W-1:0]  sat;
        logic [PCT_W-1:0]  bri;
        logic              known;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } stim_row_t;

    // directed items; known rows carry the color typed in, the rest use the predictor
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{9'd0,   7'd0,   7'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{9'd0,   7'd100, 7'd100, 1'b1, 8'd255, 8'd0,   8'd0},
        '{9'd120, 7'd100, 7'd100, 1'b1, 8'd0,   8'd255, 8'd0},
        '{9'd240, 7'd100, 7'd100, 1'b1, 8'd0,   8'd0,   8'd255},
        '{9'd60,  7'd100, 7'd100, 1'b1, 8'd255, 8'd255, 8'd0},
        '{9'd180, 7'd100, 7'd100, 1'b1, 8'd0,   8'd255, 8'd255},
        '{9'd300, 7'd100, 7'd100, 1'b1, 8'd255, 8'd0,   8'd255},
        '{9'd0,   7'd0,   7'd100, 1'b1, 8'd255, 8'd255, 8'd255},
        '{9'd511, 7'd127, 7'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{9'd360, 7'd100, 7'd100, 1'b1, 8'd255, 8'd0,   8'd255},
        '{9'd511, 7'd127, 7'd127, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd59,  7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd119, 7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd179, 7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd239, 7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd299, 7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd359, 7'd100, 7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd30,  7'd101, 7'd101, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd90,  7'd127, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd150, 7'd50,  7'd127, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd420, 7'd75,  7'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd480, 7'd100, 7'd60,  1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd210, 7'd1,   7'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{9'd270, 7'd99,  7'd99,  1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // hue[8:0], saturation[15:9], brightness[22:16], zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // red[7:0], green[15:8], blue[23:16]

    rgb_t expected_rgb_q [$];
    int   items_sent;
    int   colors_checked;
    int   fail_count;
    int   mismatch_count;
    int   wrap_hue_count;
    int   clamped_count;
    int   stall_cycles;
    bit   quiet;
    bit   rx_hold;
    bit   hold_done;

    hsv_percent_to_rgb i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // exact hsv to rgb: levels held as integers over a common denominator
    function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] hue,
                                         input logic [PCT_W-1:0] sat_in,
                                         input logic [PCT_W-1:0] bri_in);
        logic [PCT_W-1:0]  sat;
        logic [PCT_W-1:0]  bri;
        logic [3:0]        sect_raw;
        logic [SECT_W-1:0] sector;
        logic [31:0]       frac;
        logic [31:0]       peak;
        logic [31:0]       base;
        logic [31:0]       ramp;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] lo;
        logic [CHAN_W-1:0] up;
        logic [CHAN_W-1:0] dn;
        rgb_t              color;
        sat      = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
        bri      = (bri_in > PCT_MAX) ? PCT_MAX : bri_in;
        sect_raw = 4'(hue / HUE_SPAN);
        sector   = (sect_raw > 4'(SECT_LAST)) ? SECT_LAST : sect_raw[SECT_W-1:0];
        frac     = 32'(hue % HUE_SPAN);
        peak     = 32'd255 * 32'(bri) * 32'd6000;
        base     = 32'd255 * 32'(bri) * (32'd100 - 32'(sat)) * 32'd60;
        ramp     = 32'd255 * 32'(bri) * 32'(sat) * frac;
        hi       = CHAN_W'(peak / LEVEL_DEN);
        lo       = CHAN_W'(base / LEVEL_DEN);
        up       = CHAN_W'((base + ramp) / LEVEL_DEN);
        dn       = CHAN_W'((peak - ramp) / LEVEL_DEN);
        case (sector)
            SECT_RED_UP: begin
                color = '{blue: lo, green: up, red: hi};
            end
            SECT_GRN_PEAK: begin
                color = '{blue: lo, green: hi, red: dn};
            end
            SECT_GRN_UP: begin
                color = '{blue: up, green: hi, red: lo};
            end
            SECT_BLU_PEAK: begin
                color = '{blue: hi, green: dn, red: lo};
            end
            SECT_BLU_UP: begin
                color = '{blue: hi, green: lo, red: up};
            end
            default: begin
                color = '{blue: dn, green: lo, red: hi};
            end
        endcase
        return color;
    endfunction

    // offer one item, with an optional idle burst ahead of it, and log its color
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                              input logic [PCT_W-1:0] bri, input logic known,
                              input rgb_t typed);
        int gap;
        if (!quiet && !rx_hold && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, bri, sat, hue};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_rgb_q.push_back(known ? typed : predict_rgb(hue, sat, bri));
        items_sent++;
        if (hue >= 9'd360) wrap_hue_count++;
        if (sat > PCT_MAX || bri > PCT_MAX) clamped_count++;
    endtask

    // percent field: mostly in range, some at the ends, some above 100
    function automatic logic [PCT_W-1:0] pick_percent();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return PCT_W'($urandom_range(101, 127));
        if (roll == 1) return ($urandom_range(0, 1) != 0) ? PCT_MAX : '0;
        return PCT_W'($urandom_range(0, 100));
    endfunction

    // stimulus and end of run
    initial begin
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] bri;
        int               roll;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_pixel(DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].bri, DIRECTED[i].known,
                       '{blue: DIRECTED[i].blue, green: DIRECTED[i].green,
                         red: DIRECTED[i].red});
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
            roll = $urandom_range(0, 19);
            if (roll < 2) begin
                hue = HUE_W'($urandom_range(360, 511));
            end else if (roll < 4) begin
                // sector edges, either side of a multiple of 60
                hue = HUE_W'($urandom_range(0, 5) * HUE_SPAN + $urandom_range(0, 1) * 59);
            end else begin
                hue = HUE_W'($urandom_range(0, 359));
            end
            sat = pick_percent();
            bri = pick_percent();
            send_pixel(hue, sat, bri, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        while (expected_rgb_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d items, %0d colors checked, %0d mismatches", items_sent,
                 colors_checked, mismatch_count);
        $display("run: %0d hues past 359, %0d with clamped percent, output held %0d cycles",
                 wrap_hue_count, clamped_count, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("hsv_percent_to_rgb_tb OK");
        end else begin
            $display("hsv_percent_to_rgb_tb NOT OK");
        end
        $finish;
    end

    // receiver: random holds, one long hold to back the pipeline up
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                rx_hold = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold   = 1'b0;
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // result check against the oldest expected color
    always @(posedge aclk) begin
        rgb_t actual;
        rgb_t expected;
        if (aresetn && m_tvalid && m_tready) begin
            actual = rgb_t'(m_tdata);
            if (expected_rgb_q.size() == 0) begin
                fail_count++;
                $display("unexpected color r=%0d g=%0d b=%0d", actual.red, actual.green,
                         actual.blue);
            end else begin
                expected = expected_rgb_q.pop_front();
                colors_checked++;
                if (actual.red != expected.red || actual.green != expected.green ||
                    actual.blue != expected.blue) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("color %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 colors_checked - 1, expected.red, expected.green,
                                 expected.blue, actual.red, actual.green, actual.blue);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("hsv_percent_to_rgb_tb NOT OK");
                $finish;
            end
        end else begin
            stall_cycles <= 0;
        end
    end

endmodule
